@@ rtl/core/cawc_pkg.sv @@
// Shared types and constants for the contiguous allocator with compaction.
// Used by the cell store RAM and by the top level; depends on nothing else.
package cawc_pkg;

  localparam int unsigned STORE_CELLS_DEF   = 256;
  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned SIZE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned BEGIN_W  = 8;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned ID_NUM   = 1 << ID_W;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_COMPACT = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_NO_SPACE   = 3'd1,
    STAT_DUPLICATE  = 3'd2,
    STAT_NOT_FOUND  = 3'd3,
    STAT_TABLE_FULL = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_COMPACT,
    S_DONE
  } state_e;

endpackage

@@ rtl/core/contiguous_allocator_with_compaction.sv @@
// Contiguous allocator with compaction: top level with control and owner bookkeeping.
// Depends on cawc_pkg and instantiates cawc_cell_ram.
//
// The block keeps a store of STORE_CELLS cells, each holding an owner id or zero,
// and accepts one item at a time. Allocate writes the new block from the top of
// the store upward when it succeeds; free and compact walk the used cells
// below the top of the store, one cell per cycle through the cell store's read
// port. Cells above the top are never read, so the store needs no clearing
// after reset. A finished result waits in an output register and the next item
// may be taken meanwhile.
module contiguous_allocator_with_compaction import cawc_pkg::*; #(
  parameter int unsigned STORE_CELLS   = STORE_CELLS_DEF,
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,   // [7:0] process_id, [15:8] block_size
  input  logic [1:0]  s_tuser_i,   // [1:0] operation
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o,   // [7:0] first cell, [14:8] live_count, [15] zero
  output logic [2:0]  m_tuser_o    // [2:0] status
);

  localparam int unsigned CW   = $clog2(STORE_CELLS);
  localparam int unsigned TW   = CW + 1;
  localparam int unsigned NW   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CMPW = (TW > SIZE_W) ? TW : SIZE_W;

  state_e state_q, state_d;

  logic [TW-1:0]     top_q, top_d;
  logic [NW-1:0]     count_q, count_d;
  logic [ID_NUM-1:0] live_q, live_d;
  logic              rd_vld_q, rd_vld_d;
  logic              m_valid_q, m_valid_d;

  logic [ID_W-1:0]   id_q, id_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [TW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     rd_idx_q, rd_idx_d;
  logic [TW-1:0]     wptr_q, wptr_d;
  logic [TW-1:0]     ntop_q, ntop_d;
  status_e           res_status_q, res_status_d;
  logic [TW-1:0]     res_begin_q, res_begin_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [BEGIN_W-1:0]  out_begin_q, out_begin_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;

  logic              ram_we, ram_re;
  logic [CW-1:0]     ram_waddr, ram_raddr;
  logic [ID_W-1:0]   ram_wdata, ram_rdata;

  op_e               in_op;
  logic [ID_W-1:0]   in_id;
  logic [SIZE_W-1:0] in_size;
  logic [TW-1:0]     room;
  status_e           alloc_status;
  logic              free_ok;
  logic              issue;
  logic              walk_done;
  logic              load_out;

  assign in_op   = op_e'(s_tuser_i);
  assign in_id   = s_tdata_i[7:0];
  assign in_size = s_tdata_i[15:8];
  assign room    = TW'(STORE_CELLS) - top_q;
  assign free_ok = (in_id != '0) && live_q[in_id];

  always_comb begin
    if (in_id == '0) begin
      alloc_status = STAT_NOT_FOUND;
    end else if (live_q[in_id]) begin
      alloc_status = STAT_DUPLICATE;
    end else if (count_q >= NW'(TABLE_ENTRIES)) begin
      alloc_status = STAT_TABLE_FULL;
    end else if ((in_size == '0) || (CMPW'(room) < CMPW'(in_size))) begin
      alloc_status = STAT_NO_SPACE;
    end else begin
      alloc_status = STAT_OK;
    end
  end

  // Walks issue one read per cycle below the top; read data returns in the next cycle from the store's read register.
  assign issue     = (idx_q < top_q);
  assign walk_done = !issue && !rd_vld_q;
  assign load_out  = !m_valid_q || m_tready_i;

  assign s_tready_o = (state_q == S_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          unique case (in_op)
            OP_ALLOC:   state_d = (alloc_status == STAT_OK) ? S_ALLOC : S_DONE;
            OP_FREE:    state_d = free_ok ? S_FREE : S_DONE;
            OP_COMPACT: state_d = S_COMPACT;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_ALLOC: begin
        if (size_q == SIZE_W'(1)) begin
          state_d = S_DONE;
        end
      end
      S_FREE, S_COMPACT: begin
        if (walk_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    top_d        = top_q;
    count_d      = count_q;
    live_d       = live_q;
    rd_vld_d     = 1'b0;
    id_d         = id_q;
    size_d       = size_q;
    idx_d        = idx_q;
    rd_idx_d     = rd_idx_q;
    wptr_d       = wptr_q;
    ntop_d       = ntop_q;
    res_status_d = res_status_q;
    res_begin_d  = res_begin_q;
    out_status_d = out_status_q;
    out_begin_d  = out_begin_q;
    out_count_d  = out_count_q;
    m_valid_d    = m_valid_q && !m_tready_i;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[CW-1:0];
    ram_wdata    = id_q;
    ram_re       = 1'b0;
    ram_raddr    = idx_q[CW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          id_d         = in_id;
          size_d       = in_size;
          idx_d        = '0;
          wptr_d       = '0;
          ntop_d       = '0;
          res_status_d = STAT_OK;
          res_begin_d  = '0;
          unique case (in_op)
            OP_ALLOC: begin
              res_status_d = alloc_status;
              if (alloc_status == STAT_OK) begin
                idx_d          = top_q;
                res_begin_d    = top_q;
                live_d[in_id]  = 1'b1;
                count_d        = count_q + NW'(1);
              end
            end
            OP_FREE: begin
              if (free_ok) begin
                live_d[in_id] = 1'b0;
                count_d       = count_q - NW'(1);
              end else begin
                res_status_d  = STAT_NOT_FOUND;
              end
            end
            OP_COMPACT: ;
            default: ;
          endcase
        end
      end
      S_ALLOC: begin
        ram_we = 1'b1;
        idx_d  = idx_q + TW'(1);
        size_d = size_q - SIZE_W'(1);
        if (size_q == SIZE_W'(1)) begin
          top_d = idx_q + TW'(1);
        end
      end
      S_FREE: begin
        if (issue) begin
          ram_re   = 1'b1;
          idx_d    = idx_q + TW'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q[CW-1:0];
        end
        if (rd_vld_q) begin
          ram_waddr = rd_idx_q;
          ram_wdata = '0;
          if (ram_rdata == id_q) begin
            ram_we = 1'b1;
          end else if (ram_rdata != '0) begin
            ntop_d = TW'(rd_idx_q) + TW'(1);
          end
        end
        if (walk_done) begin
          top_d = ntop_q;
        end
      end
      S_COMPACT: begin
        if (issue) begin
          ram_re   = 1'b1;
          idx_d    = idx_q + TW'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q[CW-1:0];
        end
        // The write pointer never passes the cell being read, so reads stay valid.
        if (rd_vld_q && (ram_rdata != '0)) begin
          ram_we    = 1'b1;
          ram_waddr = wptr_q[CW-1:0];
          ram_wdata = ram_rdata;
          wptr_d    = wptr_q + TW'(1);
        end
        if (walk_done) begin
          top_d       = wptr_q;
          res_begin_d = wptr_q;
        end
      end
      S_DONE: begin
        if (load_out) begin
          m_valid_d    = 1'b1;
          out_status_d = res_status_q;
          out_begin_d  = BEGIN_W'(res_begin_q);
          out_count_d  = COUNT_W'(count_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      top_q     <= '0;
      count_q   <= '0;
      live_q    <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      top_q     <= top_d;
      count_q   <= count_d;
      live_q    <= live_d;
      rd_vld_q  <= rd_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    size_q       <= size_d;
    idx_q        <= idx_d;
    rd_idx_q     <= rd_idx_d;
    wptr_q       <= wptr_d;
    ntop_q       <= ntop_d;
    res_status_q <= res_status_d;
    res_begin_q  <= res_begin_d;
    out_status_q <= out_status_d;
    out_begin_q  <= out_begin_d;
    out_count_q  <= out_count_d;
  end

  cawc_cell_ram #(
    .DEPTH (STORE_CELLS),
    .WIDTH (ID_W)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {1'b0, out_count_q, out_begin_q};
  assign m_tuser_o  = out_status_q;

endmodule

@@ rtl/core/cawc_cell_ram.sv @@
// Cell store: one write port and one read port with registered read data.
// Depends on cawc_pkg for default sizes.
module cawc_cell_ram import cawc_pkg::*; #(
  parameter int unsigned DEPTH = STORE_CELLS_DEF,
  parameter int unsigned WIDTH = ID_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sim/contiguous_allocator_with_compaction_test.sv @@
// Testbench for the contiguous allocator with compaction: random and directed
// allocate, free, compact and unused-code items checked against a behavioral model of the store.
// Depends on cawc_pkg and the top level contiguous_allocator_with_compaction.
module contiguous_allocator_with_compaction_test;
  import cawc_pkg::*;

  localparam int unsigned CELLS   = STORE_CELLS_DEF;
  localparam int unsigned ENTRIES = TABLE_ENTRIES_DEF;

  typedef struct packed {
    status_e         status;
    logic [BEGIN_W-1:0] first_cell;
    logic [COUNT_W-1:0] live_count;
  } answer_t;

  int unsigned mismatch_count = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch in %s: got %0d, want %0d", what, got, want);
    mismatch_count++;
  endtask

  // Behavioral copy of the store and owner table; answers wait in a queue.
  class alloc_scoreboard;
    logic [ID_W-1:0] cells[CELLS];
    logic [ID_W-1:0] owners[ENTRIES];
    int unsigned     begins[ENTRIES];
    int unsigned     sizes[ENTRIES];
    int unsigned     live;
    answer_t         pending[$];

    function new();
      foreach (cells[i]) cells[i] = '0;
      foreach (owners[i]) begin
        owners[i] = '0;
        begins[i] = 0;
        sizes[i]  = 0;
      end
      live = 0;
    endfunction

    function int unsigned top_of_store();
      int unsigned t;
      t = CELLS;
      while (t > 0 && cells[t-1] == 0) t--;
      return t;
    endfunction

    function int slot_of(logic [ID_W-1:0] id);
      for (int k = 0; k < live; k++) if (owners[k] == id) return k;
      return -1;
    endfunction

    function bit has_id(logic [ID_W-1:0] id);
      return slot_of(id) >= 0;
    endfunction

    function void note_item(logic [1:0] op, logic [ID_W-1:0] id, logic [SIZE_W-1:0] size);
      answer_t     a;
      int unsigned t, w, last;
      int          k;
      int unsigned remap[CELLS+1];
      a.status = STAT_OK;
      a.first_cell = '0;
      if (op == OP_ALLOC) begin
        t = top_of_store();
        if (id == 0) a.status = STAT_NOT_FOUND;
        else if (has_id(id)) a.status = STAT_DUPLICATE;
        else if (live >= ENTRIES) a.status = STAT_TABLE_FULL;
        else if (size == 0 || CELLS - t < size) a.status = STAT_NO_SPACE;
        else begin
          for (int i = 0; i < size; i++) cells[t+i] = id;
          owners[live] = id;
          begins[live] = t;
          sizes[live]  = size;
          live++;
          a.first_cell = t[BEGIN_W-1:0];
        end
      end else if (op == OP_FREE) begin
        k = (id == 0) ? -1 : slot_of(id);
        if (k < 0) a.status = STAT_NOT_FOUND;
        else begin
          for (int i = begins[k]; i < begins[k] + sizes[k] && i < CELLS; i++) cells[i] = '0;
          last = live - 1;
          owners[k] = owners[last];
          begins[k] = begins[last];
          sizes[k]  = sizes[last];
          owners[last] = '0;
          begins[last] = 0;
          sizes[last]  = 0;
          live--;
        end
      end else if (op == OP_COMPACT) begin
        w = 0;
        for (int i = 0; i < CELLS; i++) begin
          remap[i] = w;
          if (cells[i] != 0) begin
            logic [ID_W-1:0] v;
            v = cells[i];
            cells[i] = '0;
            cells[w] = v;
            w++;
          end
        end
        remap[CELLS] = w;
        for (int j = 0; j < live; j++) begins[j] = remap[begins[j]];
        a.first_cell = w[BEGIN_W-1:0];
      end
      a.live_count = live[COUNT_W-1:0];
      pending.push_back(a);
    endfunction

    task check_result(logic [15:0] data, logic [2:0] user);
      answer_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      want = pending.pop_front();
      if (user != want.status) report("status", user, want.status);
      if (data[7:0] != want.first_cell) report("first cell", data[7:0], want.first_cell);
      if (data[14:8] != want.live_count) report("live_count", data[14:8], want.live_count);
      if (data[15] != 1'b0) report("pad bit", data[15], 0);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [15:0] s_tdata_i = '0;
  logic [1:0]  s_tuser_i = '0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [15:0] m_tdata_o;
  logic [2:0]  m_tuser_o;

  alloc_scoreboard board = new();
  bit          sending_done = 1'b0;
  int unsigned hold_off = 0;

  always #5 clk_i = ~clk_i;

  contiguous_allocator_with_compaction u_dut (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .s_tdata_i, .s_tuser_i,
    .m_tvalid_o, .m_tready_i, .m_tdata_o, .m_tuser_o
  );

  // The valid line stays high into the next item when no gap is drawn.
  task automatic send_item(input logic [1:0] op, input logic [7:0] id, input logic [7:0] size);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= {size, id};
    do @(posedge clk_i); while (!s_tready_o);
    board.note_item(op, id, size);
  endtask

  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending.size() != 0);
  endtask

  // Mostly ids from a small pool so that frees and duplicates hit live owners.
  function automatic logic [7:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'($urandom_range(0, 255));
    if (r == 1 && board.live > 0) return board.owners[$urandom_range(0, board.live - 1)];
    return 8'($urandom_range(1, 80));
  endfunction

  function automatic logic [7:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'($urandom_range(0, 255));
    if (r == 1) return 8'd0;
    return 8'($urandom_range(1, 12));
  endfunction

  // Receiver: random stalls, plus one long hold-off requested by the sender.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off != 0) begin
        m_tready_i <= 1'b0;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        m_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      board.check_result(m_tdata_o, m_tuser_o);
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-store cases, field extremes, every status and the ignored code.
    send_item(OP_COMPACT, 8'hff, 8'hff);
    send_item(OP_FREE, 8'd5, 8'd0);
    send_item(OP_ALLOC, 8'd0, 8'd4);
    send_item(OP_FREE, 8'd0, 8'd0);
    send_item(OP_ALLOC, 8'd1, 8'd0);
    send_item(OP_ALLOC, 8'hff, 8'd10);
    send_item(OP_ALLOC, 8'hff, 8'd3);
    send_item(OP_ALLOC, 8'd2, 8'hff);
    send_item(OP_ALLOC, 8'd3, 8'd246);
    send_item(OP_ALLOC, 8'd4, 8'd1);
    send_item(OP_COMPACT, 8'd0, 8'd0);
    send_item(OP_FREE, 8'hff, 8'hff);
    send_item(OP_COMPACT, 8'd0, 8'd0);
    send_item(2'd3, 8'haa, 8'h55);
    send_item(OP_FREE, 8'd3, 8'd0);
    send_item(OP_ALLOC, 8'd4, 8'd1);
    send_item(OP_FREE, 8'd4, 8'd0);
    // Fill the table with one-cell blocks, then overflow it.
    for (int i = 0; i < 66; i++) send_item(OP_ALLOC, 8'(100 + i), 8'd1);
    send_item(OP_COMPACT, 8'd0, 8'd0);
    for (int i = 0; i < 66; i += 2) send_item(OP_FREE, 8'(100 + i), 8'd0);
    send_item(OP_COMPACT, 8'd0, 8'd0);

    // The sender pauses here until the block is drained.
    wait_drained();
    hold_off = 300;
    for (int i = 0; i < 12; i++) send_item(OP_ALLOC, 8'(200 + i), 8'd2);

    for (int n = 0; n < 720; n++) begin
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) send_item(OP_ALLOC, pick_id(), pick_size());
      else if (r < 85) send_item(OP_FREE, pick_id(), pick_size());
      else if (r < 97) send_item(OP_COMPACT, 8'($urandom), 8'($urandom));
      else send_item(2'd3, 8'($urandom), 8'($urandom));
      if (n == 400) wait_drained();
    end
    sending_done = 1'b1;
  end

  initial begin
    wait (sending_done);
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
